// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg - shared types and constants of the page frame allocator
// Sizes, register codes, status codes and the structs that travel between
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

   // Sizing of the frame table and the page map
   localparam int MAX_FRAMES = 64;
   localparam int MAX_PROCS  = 16;
   localparam int MAX_PAGES  = 64;

   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int PROC_W  = $clog2(MAX_PROCS);
   localparam int PAGE_W  = $clog2(MAX_PAGES);
   localparam int SLOT_W  = PROC_W + PAGE_W;
   localparam int SLOTS   = MAX_PROCS * MAX_PAGES;

   // Frame search: groups of eight frames, registered per group
   localparam int GRP_N  = 8;
   localparam int GRP_W  = $clog2(GRP_N);
   localparam int NGRP   = (MAX_FRAMES + GRP_N - 1) / GRP_N;

   // Request queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   localparam int CFG_FRAMES_W = 7;
   localparam int CFG_PROCS_W  = 5;
   localparam int CFG_PAGES_W  = 7;
   localparam int CSR_DATA_W   = 7;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_IN_USE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGES_PER_PROCESS = 2'd2;

   localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = 7'd64;
   localparam logic [CFG_PROCS_W-1:0]  PROCS_RESET  = 5'd16;
   localparam logic [CFG_PAGES_W-1:0]  PAGES_RESET  = 7'd64;

   // Result fields
   localparam int RSP_FRAME_W = 6;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_PID    = 3'd1,
      ST_BAD_PAGE   = 3'd2,
      ST_MAPPED     = 3'd3,
      ST_FULL       = 3'd4,
      ST_NOT_MAPPED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_BAD_PID,
      KIND_BAD_PAGE,
      KIND_ALLOC,
      KIND_FREE
   } kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   // Beats on the ports
   typedef struct packed {
      logic       req_type;
      logic [7:0] proc_id;
      logic [7:0] page_num;
   } req_item_type;

   typedef struct packed {
      status_type             status;
      logic [RSP_FRAME_W-1:0] frame_index;
   } rsp_item_type;

   // Saturated configuration
   typedef struct packed {
      logic [CFG_FRAMES_W-1:0] nframes;
      logic [CFG_PROCS_W-1:0]  nprocs;
      logic [CFG_PAGES_W-1:0]  npages;
   } cfg_type;

   // Classified request held in the queue
   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

   // Page map entry
   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } map_entry_type;

endpackage

`default_nettype wire

// ===== rtl/page_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_core - first-free page frame allocator
// Allocates and frees physical frames for (process, page) pairs, keeping a
// frame busy table and a page map cleared after reset.
//
//   channel  direction  handshake          beat
//   req      in         req_valid/stall    req_type, proc_id, page_num
//   rsp      out        rsp_valid/stall    status, frame_index
//   csr      in         csr_wr_en          csr_index, csr_wdata
//
// In the back end a request first reads the page map in BK_IDLE, then
// updates the frame table and map in BK_EXEC once the output register is
// free. After reset all 1024 page map slots are swept with req_stall
// high. req_stall also rises when the two-beat
// queue fills; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pfa_pkg::req_item_type               req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pfa_pkg::rsp_item_type                    rsp_item,
   input  wire logic                                csr_wr_en,
   input  wire logic [pfa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import pfa_pkg::*;

   logic [CFG_FRAMES_W-1:0] frames_ff, frames_in;
   logic [CFG_PROCS_W-1:0]  procs_ff, procs_in;
   logic [CFG_PAGES_W-1:0]  pages_ff, pages_in;
   cfg_type                 cfg;
   back_stat_type           back_stat;
   q_head_type              q_head;

   // Register writes; unknown indexes drop
   always_comb begin
      frames_in = frames_ff;
      procs_in  = procs_ff;
      pages_in  = pages_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAMES_IN_USE:     frames_in = CFG_FRAMES_W'(csr_wdata);
            CSR_PROCESS_COUNT:     procs_in  = CFG_PROCS_W'(csr_wdata);
            CSR_PAGES_PER_PROCESS: pages_in  = CFG_PAGES_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
         procs_ff  <= PROCS_RESET;
         pages_ff  <= PAGES_RESET;
      end else begin
         frames_ff <= frames_in;
         procs_ff  <= procs_in;
         pages_ff  <= pages_in;
      end
   end

   // Saturate counts to the table sizes
   assign cfg.nframes = (frames_ff > CFG_FRAMES_W'(MAX_FRAMES)) ?
                        CFG_FRAMES_W'(MAX_FRAMES) : frames_ff;
   assign cfg.nprocs  = (procs_ff > CFG_PROCS_W'(MAX_PROCS)) ?
                        CFG_PROCS_W'(MAX_PROCS) : procs_ff;
   assign cfg.npages  = (pages_ff > CFG_PAGES_W'(MAX_PAGES)) ?
                        CFG_PAGES_W'(MAX_PAGES) : pages_ff;

   pfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .cfg       (cfg),
      .back_stat (back_stat),
      .q_head    (q_head)
   );

   pfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_head    (q_head),
      .back_stat (back_stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram - generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pfa_front.sv =====
// ----------------------------------------------------------------------------
// pfa_front - request intake and classification
// Checks the process id and page number, forms the page map slot and
// holds classified requests in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pfa_pkg::req_item_type req_item,
   input  wire pfa_pkg::cfg_type      cfg,
   input  wire pfa_pkg::back_stat_type back_stat,
   output pfa_pkg::q_head_type        q_head
);

   import pfa_pkg::*;

   q_item_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   q_item_type        cls_item;
   logic              push;
   logic              pop;

   // Classify: pid first, then page, then the request type
   always_comb begin
      cls_item.slot = {req_item.proc_id[PROC_W-1:0], req_item.page_num[PAGE_W-1:0]};
      priority if (req_item.proc_id >= 8'(cfg.nprocs)) begin
         cls_item.kind = KIND_BAD_PID;
      end else if (req_item.page_num >= 8'(cfg.npages)) begin
         cls_item.kind = KIND_BAD_PAGE;
      end else if (req_item.req_type) begin
         cls_item.kind = KIND_FREE;
      end else begin
         cls_item.kind = KIND_ALLOC;
      end
   end

   // Stall while the queue is full or the page map is being cleared
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH)) || back_stat.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = back_stat.pop && (count_ff != '0);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls_item;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/pfa_back.sv =====
// ----------------------------------------------------------------------------
// pfa_back - request execution
// Reads the page map entry of a queued request, picks the lowest free
// frame, updates the frame table and the map, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pfa_pkg::cfg_type      cfg,
   input  wire pfa_pkg::q_head_type   q_head,
   output pfa_pkg::back_stat_type     back_stat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output pfa_pkg::rsp_item_type      rsp_item
);

   import pfa_pkg::*;

   localparam int MAP_W = $bits(map_entry_type);

   back_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]   clr_cnt_ff, clr_cnt_in;
   q_item_type          work_ff;
   logic [MAX_FRAMES-1:0] busy_ff, busy_in;
   logic [NGRP-1:0]     grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]    grp_low_ff [NGRP];
   logic [GRP_W-1:0]    grp_low_in [NGRP];
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic [NGRP*GRP_N-1:0] elig;
   logic                pick_any;
   logic [FRAME_W-1:0]  pick_frame;
   logic                out_free;
   logic                load_work;
   logic                done;
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   map_entry_type       ram_wr_data;
   logic                ram_rd_en;
   map_entry_type       ram_rd_data;
   logic [MAP_W-1:0]    ram_rd_raw;
   logic                busy_set;
   logic                busy_clr;
   logic [FRAME_W-1:0]  busy_idx;

   pfa_ram #(
      .WIDTH (MAP_W),
      .DEPTH (SLOTS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (MAP_W'(ram_wr_data)),
      .rd_en   (ram_rd_en),
      .rd_addr (q_head.item.slot),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = map_entry_type'(ram_rd_raw);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Mark frames that are free and below the configured count
   always_comb begin
      elig = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         elig[i] = !busy_ff[i] && (i < int'(cfg.nframes));
      end
   end

   // Lowest free frame within each group of eight
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = 1'b0;
         grp_low_in[g] = '0;
         for (int b = GRP_N - 1; b >= 0; b--) begin
            if (elig[g*GRP_N + b]) begin
               grp_any_in[g] = 1'b1;
               grp_low_in[g] = GRP_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_any_ff <= grp_any_in;
      grp_low_ff <= grp_low_in;
   end

   // Lowest group holding a free frame
   always_comb begin
      pick_any   = 1'b0;
      pick_frame = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_any   = 1'b1;
            pick_frame = FRAME_W'(g * GRP_N + int'(grp_low_ff[g]));
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_cnt_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_head.valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // Outputs of each state
   always_comb begin
      load_work   = 1'b0;
      done        = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = work_ff.slot;
      ram_wr_data = '0;
      busy_set    = 1'b0;
      busy_clr    = 1'b0;
      busy_idx    = ram_rd_data.frame;
      rsp_item_in = rsp_item_ff;
      back_stat.clearing = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            back_stat.clearing = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
         end
         BK_IDLE: begin
            if (q_head.valid) begin
               load_work = 1'b1;
               ram_rd_en = 1'b1;
            end
         end
         BK_EXEC: begin
            if (out_free) begin
               done = 1'b1;
               rsp_item_in.frame_index = '0;
               unique case (work_ff.kind)
                  KIND_BAD_PID:  rsp_item_in.status = ST_BAD_PID;
                  KIND_BAD_PAGE: rsp_item_in.status = ST_BAD_PAGE;
                  KIND_ALLOC: begin
                     priority if (ram_rd_data.valid) begin
                        rsp_item_in.status      = ST_MAPPED;
                        rsp_item_in.frame_index = RSP_FRAME_W'(ram_rd_data.frame);
                     end else if (pick_any) begin
                        rsp_item_in.status      = ST_OK;
                        rsp_item_in.frame_index = RSP_FRAME_W'(pick_frame);
                        busy_set          = 1'b1;
                        busy_idx          = pick_frame;
                        ram_wr_en         = 1'b1;
                        ram_wr_data.valid = 1'b1;
                        ram_wr_data.frame = pick_frame;
                     end else begin
                        rsp_item_in.status = ST_FULL;
                     end
                  end
                  KIND_FREE: begin
                     if (ram_rd_data.valid) begin
                        rsp_item_in.status      = ST_OK;
                        rsp_item_in.frame_index = RSP_FRAME_W'(ram_rd_data.frame);
                        busy_clr  = 1'b1;
                        ram_wr_en = 1'b1;
                     end else begin
                        rsp_item_in.status = ST_NOT_MAPPED;
                     end
                  end
                  default: rsp_item_in.status = ST_BAD_PID;
               endcase
            end
         end
         default: begin
            back_stat.clearing = 1'b1;
         end
      endcase
      back_stat.pop = load_work;
   end

   // Hold the result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Update the frame table
   always_comb begin
      busy_in = busy_ff;
      if (busy_set) begin
         busy_in[busy_idx] = 1'b1;
      end else if (busy_clr) begin
         busy_in[busy_idx] = 1'b0;
      end
   end

   assign clr_cnt_in = (state_ff == BK_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_work) begin
         work_ff <= q_head.item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== rtl/pfa_checker.sv =====
// ----------------------------------------------------------------------------
// pfa_checker - port-level checks of the page frame allocator
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire pfa_pkg::rsp_item_type           rsp_item
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("rsp_item changed while stalled");

   // The page map sweep blocks requests once reset is released
   a_clear_stall: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken during page map sweep");

   // No result can appear right after reset
   a_no_early_rsp: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result shown too soon after reset");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

`default_nettype wire
